// ----- sv/ptc_pkg.sv -----
package ptc_pkg;

  // Pipeline depth: six stages of compensation, five of pressure scaling.
  localparam int COMP_STAGES = 6;
  localparam int PRES_STAGES = 5;
  localparam int NUM_STAGES  = COMP_STAGES + PRES_STAGES;

  localparam int COEF_W  = 16;
  localparam int RAW_W   = 24;
  localparam int DT_W    = 25;
  localparam int WIDE_W  = 40;
  localparam int PRES_W  = 32;
  localparam int TEMP_W  = 21;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  // Temperature reference of the second-order split (20.00 C) and the offset
  // that moves the very-low branch threshold to -15.00 C.
  localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
  localparam logic signed [18:0] VLOW_OFFS  = 19'sd3500;
  localparam logic signed [17:0] VLOW_LIMIT = -18'sd3500;

  typedef enum logic [2:0] {
    REG_SENS_BASE   = 3'd0,
    REG_OFFSET_BASE = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens_base;
    logic [COEF_W-1:0] offset_base;
    logic [COEF_W-1:0] sens_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } coef_t;

  typedef logic [NUM_STAGES:1] stage_en_t;

  // Result of the compensation stages, handed to the pressure stages.
  typedef struct packed {
    logic              err;
    logic [RAW_W-1:0]  d1;
    logic [WIDE_W-1:0] sens;
    logic [WIDE_W-1:0] off;
    logic [TEMP_W-1:0] temp;
  } comp_t;

endpackage

// ----- sv/ptc_regs.sv -----
module ptc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ptc_pkg::APB_W-1:0]   pwdata,
  output logic [ptc_pkg::APB_W-1:0]   prdata,
  output ptc_pkg::coef_t              coef
);

  ptc_pkg::coef_t   coef_r;
  ptc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx   = ptc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;
  assign coef  = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ptc_pkg::REG_SENS_BASE:   coef_r.sens_base   <= pwdata[15:0];
        ptc_pkg::REG_OFFSET_BASE: coef_r.offset_base <= pwdata[15:0];
        ptc_pkg::REG_SENS_TEMP:   coef_r.sens_temp   <= pwdata[15:0];
        ptc_pkg::REG_OFFSET_TEMP: coef_r.offset_temp <= pwdata[15:0];
        ptc_pkg::REG_REF_TEMP:    coef_r.ref_temp    <= pwdata[15:0];
        ptc_pkg::REG_TEMP_SLOPE:  coef_r.temp_slope  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ptc_pkg::REG_SENS_BASE:   prdata = {16'd0, coef_r.sens_base};
      ptc_pkg::REG_OFFSET_BASE: prdata = {16'd0, coef_r.offset_base};
      ptc_pkg::REG_SENS_TEMP:   prdata = {16'd0, coef_r.sens_temp};
      ptc_pkg::REG_OFFSET_TEMP: prdata = {16'd0, coef_r.offset_temp};
      ptc_pkg::REG_REF_TEMP:    prdata = {16'd0, coef_r.ref_temp};
      ptc_pkg::REG_TEMP_SLOPE:  prdata = {16'd0, coef_r.temp_slope};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- sv/ptc_comp.sv -----
module ptc_comp (
  input  logic                       clk,
  input  ptc_pkg::stage_en_t         en,
  input  ptc_pkg::coef_t             coef,
  input  logic [ptc_pkg::RAW_W-1:0]  d1,
  input  logic [ptc_pkg::RAW_W-1:0]  d2,
  output ptc_pkg::comp_t             comp
);

  // Stage 1: temperature difference.
  logic [23:0]        s1_d1_r;
  logic signed [24:0] s1_dt_r;
  logic               s1_err_r;
  logic signed [24:0] dt_nxt;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coef.ref_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1_r  <= d1;
      s1_dt_r  <= dt_nxt;
      s1_err_r <= (d1 == '0) || (d2 == '0);
    end
  end

  // Stage 2: the four products of dT.
  logic [23:0]        s2_d1_r;
  logic               s2_err_r;
  logic signed [40:0] s2_c3dt_r, s2_c4dt_r, s2_c6dt_r;
  logic [48:0]        s2_dtsq_r;
  logic signed [41:0] c3dt, c4dt, c6dt;
  logic signed [49:0] dtsq;

  assign c3dt = $signed({1'b0, coef.sens_temp}) * s1_dt_r;
  assign c4dt = $signed({1'b0, coef.offset_temp}) * s1_dt_r;
  assign c6dt = $signed({1'b0, coef.temp_slope}) * s1_dt_r;
  assign dtsq = s1_dt_r * s1_dt_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1_r   <= s1_d1_r;
      s2_err_r  <= s1_err_r;
      s2_c3dt_r <= c3dt[40:0];
      s2_c4dt_r <= c4dt[40:0];
      s2_c6dt_r <= c6dt[40:0];
      s2_dtsq_r <= dtsq[48:0];
    end
  end

  // Stage 3: first-order sensitivity, offset and temperature step. Signed
  // divisions by powers of two round toward zero by biasing negative values.
  logic [23:0]        s3_d1_r;
  logic               s3_err_r;
  logic signed [39:0] s3_sens1_r, s3_off1_r;
  logic signed [17:0] s3_q_r;
  logic [17:0]        s3_t2_r;
  logic signed [40:0] c3dt_adj, c4dt_adj, c6dt_adj;
  logic signed [32:0] sens_div;
  logic signed [33:0] off_div;
  logic signed [17:0] q_nxt;
  logic [50:0]        dtsq3;
  logic [17:0]        t2_nxt;

  assign c3dt_adj = s2_c3dt_r + (s2_c3dt_r[40] ? 41'sd255 : 41'sd0);
  assign c4dt_adj = s2_c4dt_r + (s2_c4dt_r[40] ? 41'sd127 : 41'sd0);
  assign c6dt_adj = s2_c6dt_r + (s2_c6dt_r[40] ? 41'sd8388607 : 41'sd0);
  assign sens_div = c3dt_adj[40:8];
  assign off_div  = c4dt_adj[40:7];
  assign q_nxt    = c6dt_adj[40:23];
  assign dtsq3    = {1'b0, s2_dtsq_r, 1'b0} + {2'b00, s2_dtsq_r};
  // Below the reference the square term is 3*dT^2/2^33, above it 2*dT^2/2^37.
  assign t2_nxt   = q_nxt[17] ? dtsq3[50:33] : {5'd0, s2_dtsq_r[48:36]};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1_r    <= s2_d1_r;
      s3_err_r   <= s2_err_r;
      s3_sens1_r <= $signed({9'd0, coef.sens_base, 15'd0}) + 40'(sens_div);
      s3_off1_r  <= $signed({8'd0, coef.offset_base, 16'd0}) + 40'(off_div);
      s3_q_r     <= q_nxt;
      s3_t2_r    <= t2_nxt;
    end
  end

  // Stage 4: squares of the temperature deviations and the corrected
  // temperature. The deviation from 20.00 C equals the first-order step q.
  logic [23:0]        s4_d1_r;
  logic               s4_err_r;
  logic signed [39:0] s4_sens1_r, s4_off1_r;
  logic [34:0]        s4_qsq_r;
  logic [35:0]        s4_vsq_r;
  logic               s4_low_r, s4_vlow_r;
  logic signed [19:0] s4_temp_r;
  logic signed [35:0] qsq;
  logic signed [18:0] vlo;
  logic signed [37:0] vsq;

  assign qsq = s3_q_r * s3_q_r;
  assign vlo = 19'(s3_q_r) + ptc_pkg::VLOW_OFFS;
  assign vsq = vlo * vlo;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1_r    <= s3_d1_r;
      s4_err_r   <= s3_err_r;
      s4_sens1_r <= s3_sens1_r;
      s4_off1_r  <= s3_off1_r;
      s4_qsq_r   <= qsq[34:0];
      s4_vsq_r   <= vsq[35:0];
      s4_low_r   <= s3_q_r[17];
      s4_vlow_r  <= s3_q_r < ptc_pkg::VLOW_LIMIT;
      s4_temp_r  <= 20'(s3_q_r) + ptc_pkg::TEMP_REF - $signed({2'b00, s3_t2_r});
    end
  end

  // Stage 5: second-order offset and sensitivity terms.
  logic [23:0]        s5_d1_r;
  logic               s5_err_r;
  logic signed [39:0] s5_sens1_r, s5_off1_r;
  logic [39:0]        s5_off2_r, s5_sens2_r;
  logic signed [19:0] s5_temp_r;
  logic [39:0]        qsq3, qsq5, vsq4, vsq7, off2_nxt, sens2_nxt;

  assign qsq3 = {4'd0, s4_qsq_r, 1'b0} + {5'd0, s4_qsq_r};
  assign qsq5 = {3'd0, s4_qsq_r, 2'b00} + {5'd0, s4_qsq_r};
  assign vsq4 = {2'd0, s4_vsq_r, 2'b00};
  assign vsq7 = {1'b0, s4_vsq_r, 3'b000} - {4'd0, s4_vsq_r};

  always_comb begin
    if (s4_low_r) begin
      off2_nxt  = {1'b0, qsq3[39:1]} + (s4_vlow_r ? vsq7 : 40'd0);
      sens2_nxt = {3'd0, qsq5[39:3]} + (s4_vlow_r ? vsq4 : 40'd0);
    end else begin
      off2_nxt  = {9'd0, s4_qsq_r[34:4]};
      sens2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1_r    <= s4_d1_r;
      s5_err_r   <= s4_err_r;
      s5_sens1_r <= s4_sens1_r;
      s5_off1_r  <= s4_off1_r;
      s5_off2_r  <= off2_nxt;
      s5_sens2_r <= sens2_nxt;
      s5_temp_r  <= s4_temp_r;
    end
  end

  // Stage 6: final offset and sensitivity. The temperature cannot leave the
  // 21-bit field with 16-bit coefficients, so it is only sign-extended.
  ptc_pkg::comp_t comp_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      comp_r.err  <= s5_err_r;
      comp_r.d1   <= s5_d1_r;
      comp_r.sens <= s5_sens1_r - $signed(s5_sens2_r);
      comp_r.off  <= s5_off1_r - $signed(s5_off2_r);
      comp_r.temp <= 21'(s5_temp_r);
    end
  end

  assign comp = comp_r;

endmodule

// ----- sv/ptc_pres.sv -----
module ptc_pres (
  input  logic                        clk,
  input  ptc_pkg::stage_en_t          en,
  input  ptc_pkg::comp_t              comp,
  output logic [ptc_pkg::PRES_W-1:0]  pressure,
  output logic [ptc_pkg::TEMP_W-1:0]  temperature,
  output logic                        status
);

  // Stage 7: D1 times sensitivity as two partial products on a 20-bit split.
  logic               s7_err_r;
  logic [20:0]        s7_temp_r;
  logic signed [39:0] s7_off_r;
  logic [43:0]        s7_pp_lo_r;
  logic signed [44:0] s7_pp_hi_r;
  logic [43:0]        pp_lo;
  logic signed [44:0] pp_hi;

  assign pp_lo = comp.d1 * comp.sens[19:0];
  assign pp_hi = $signed({1'b0, comp.d1}) * $signed(comp.sens[39:20]);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_err_r   <= comp.err;
      s7_temp_r  <= comp.temp;
      s7_off_r   <= $signed(comp.off);
      s7_pp_lo_r <= pp_lo;
      s7_pp_hi_r <= pp_hi;
    end
  end

  // Stage 8: recombine the partial products.
  logic               s8_err_r;
  logic [20:0]        s8_temp_r;
  logic signed [39:0] s8_off_r;
  logic signed [63:0] s8_prod_r;
  logic signed [64:0] prod;

  assign prod = $signed({s7_pp_hi_r, 20'd0}) + $signed({21'd0, s7_pp_lo_r});

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_err_r  <= s7_err_r;
      s8_temp_r <= s7_temp_r;
      s8_off_r  <= s7_off_r;
      s8_prod_r <= prod[63:0];
    end
  end

  // Stage 9: divide by 2^21, rounding toward zero.
  logic               s9_err_r;
  logic [20:0]        s9_temp_r;
  logic signed [39:0] s9_off_r;
  logic signed [42:0] s9_pd_r;
  logic signed [63:0] prod_adj;

  assign prod_adj = s8_prod_r + (s8_prod_r[63] ? 64'sd2097151 : 64'sd0);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_err_r  <= s8_err_r;
      s9_temp_r <= s8_temp_r;
      s9_off_r  <= s8_off_r;
      s9_pd_r   <= prod_adj[63:21];
    end
  end

  // Stage 10: subtract the offset.
  logic               s10_err_r;
  logic [20:0]        s10_temp_r;
  logic signed [43:0] s10_diff_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_err_r  <= s9_err_r;
      s10_temp_r <= s9_temp_r;
      s10_diff_r <= 44'(s9_pd_r) - 44'(s9_off_r);
    end
  end

  // Stage 11: divide by 2^13 toward zero and apply the zero-conversion error.
  // The quotient fits 31 bits, so the 32-bit field never saturates.
  logic [31:0]        pres_r;
  logic [20:0]        temp_r;
  logic               status_r;
  logic signed [43:0] diff_adj;
  logic signed [30:0] pres_q;

  assign diff_adj = s10_diff_r + (s10_diff_r[43] ? 44'sd8191 : 44'sd0);
  assign pres_q   = diff_adj[43:13];

  always_ff @(posedge clk) begin
    if (en[11]) begin
      pres_r   <= s10_err_r ? '0 : 32'(pres_q);
      temp_r   <= s10_err_r ? '0 : s10_temp_r;
      status_r <= s10_err_r;
    end
  end

  assign pressure    = pres_r;
  assign temperature = temp_r;
  assign status      = status_r;

endmodule

// ----- sv/pressure_temperature_compensation.sv -----
// Channel  Direction  Beat contents (lowest bits first)
// in_*     slave      tdata: raw_pressure[23:0], raw_temperature[47:24]
// out_*    master     tdata: pressure_tenth_mbar[31:0], temperature_centi_c[52:32],
//                     zero pad[55:53]; tuser: status
// cfg_*    APB        six 16-bit coefficient registers at byte addresses 0x00..0x14
//
// One beat is accepted per cycle while in_tready is high; a result passes through
// the eleven register stages of the multiply chain before it reaches the output.
// Each stage holds while the stage after it is full and stalled, so bubbles
// collapse and a full pipeline holds eleven beats while the output waits.
// rst_n is synchronous and active low; it empties the pipeline and clears the
// coefficient registers to zero.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // raw_pressure[23:0], raw_temperature[47:24]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // pressure_tenth_mbar[31:0], temperature_centi_c[52:32]
  output logic        out_tuser,   // status
  // Coefficient register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ptc_pkg::coef_t     coef;
  ptc_pkg::comp_t     comp;
  ptc_pkg::stage_en_t en;
  ptc_pkg::stage_en_t valid_r;
  ptc_pkg::stage_en_t valid_nxt;
  logic [31:0]        pressure;
  logic [20:0]        temperature;
  logic               status;

  assign cfg_pready = 1'b1;

  // The user must keep the coefficients static while beats are in flight (the block
  // does not enforce this), as stages 1 to 3 read them directly.
  ptc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .coef    (coef)
  );

  // A stage loads when it is empty or when the stage after it loads as well.
  // The last stage is the output register.
  always_comb begin
    en[ptc_pkg::NUM_STAGES] = !valid_r[ptc_pkg::NUM_STAGES] || out_tready;
    for (int k = ptc_pkg::NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k + 1];
    end
  end

  assign valid_nxt = (en & {valid_r[ptc_pkg::NUM_STAGES-1:1], in_tvalid}) | (~en & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = valid_r[ptc_pkg::NUM_STAGES];

  // Stages 1 to 6: dT, first-order terms and second-order corrections.
  ptc_comp u_comp (
    .clk  (clk),
    .en   (en),
    .coef (coef),
    .d1   (in_tdata[23:0]),
    .d2   (in_tdata[47:24]),
    .comp (comp)
  );

  // Stages 7 to 11: pressure product, scaling and the output register.
  ptc_pres u_pres (
    .clk         (clk),
    .en          (en),
    .comp        (comp),
    .pressure    (pressure),
    .temperature (temperature),
    .status      (status)
  );

  assign out_tdata = {3'b000, temperature, pressure};
  assign out_tuser = status;

`ifndef SYNTHESIS
  // An error beat carries zero pressure and temperature.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error beat with nonzero data");

  // The input side only stalls when every stage holds a beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&valid_r))
    else $error("input stalled with an empty stage");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid && valid_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule
